// ===== rtl/core/sadm_pkg.sv =====
// shared types, codes and constants of the servo angle to duty mapper
`default_nettype none

package sadm_pkg;

  // fixed field widths
  localparam int unsigned DutyW    = 12;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned PulseW   = 20;
  localparam int unsigned IdW      = 8;
  localparam int unsigned LimW     = 5;
  localparam int unsigned DivW     = 20;
  localparam int unsigned DivStepW = 5;

  // defaults and limits
  localparam int unsigned ServoCountDef = 16;
  localparam logic [PulseW-1:0] PeriodReset = 20'd20000;
  localparam logic [LimW-1:0]   LimitReset  = 5'd16;
  localparam logic [DutyW-1:0]  DutyMax     = 12'd4095;
  localparam logic [7:0]        AngleMax    = 8'd180;
  localparam logic [AngleW-1:0] AngleHighReset = 16'd180;
  localparam logic [7:0]        RegBase     = 8'h06;

  // divider step counts per use
  localparam logic [DivStepW-1:0] StepsCal  = 5'd12;
  localparam logic [DivStepW-1:0] StepsAng  = 5'd20;
  localparam logic [DivStepW-1:0] StepsRead = 5'd8;

  // configuration register indexes
  localparam logic RegPeriod = 1'b0;
  localparam logic RegLimit  = 1'b1;

  typedef enum logic [1:0] {
    ACT_CAL   = 2'd0,
    ACT_ANGLE = 2'd1,
    ACT_DUTY  = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic                start;
    logic [DivW-1:0]     rem0;
    logic [DivW-1:0]     dividend;
    logic [DivW-1:0]     divisor;
    logic [DivStepW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [DivW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/sadm_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module sadm_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sadm_pkg::div_req_t req_i,
  output sadm_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned W = sadm_pkg::DivW;

  logic [W-1:0]                  rem_q, quo_q, dvs_q;
  logic [sadm_pkg::DivStepW-1:0] cnt_q;
  logic                          busy_q, done_q;
  logic [W+1:0]                  diff;
  logic                          ge;

  // trial subtract of the shifted remainder
  assign diff = {1'b0, rem_q, quo_q[W-1]} - {2'b00, dvs_q};
  assign ge   = ~diff[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == sadm_pkg::DivStepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/servo_angle_duty_mapper.sv =====
// top level: per-servo calibration store and angle/duty mapping sequencer
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_ready_o  | action, servo_id, angle, cal lo/hi angle,
//          |           |                          | min/max pulse, duty_request, write_chip
//  out     | output    | out_valid_o / out_ready_i| status, write_valid, reg_addr,
//          |           |                          | duty_out, angle_out
//  cfg     | input     | cfg_we_i                 | cfg_addr_i, cfg_wdata_i
//
// one word at a time: in_ready_o is high only while the sequencer is idle
// each divide runs the shared divider for its step count: 12 steps per calibration
// pulse, 20 for the set-angle slope and 8 for the angle read-back
// the result is held in output registers until out_ready_i takes it
// reset (async, active low) loads calibration and duty defaults into flops at once
`default_nettype none

module servo_angle_duty_mapper #(
  parameter int unsigned SERVO_COUNT = sadm_pkg::ServoCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_addr_i,
  input  wire logic [sadm_pkg::PulseW-1:0]   cfg_wdata_i,
  // input words
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [sadm_pkg::IdW-1:0]      servo_id_i,
  input  wire logic [7:0]                    angle_i,
  input  wire logic signed [sadm_pkg::AngleW-1:0] cal_lo_angle_i,
  input  wire logic signed [sadm_pkg::AngleW-1:0] cal_hi_angle_i,
  input  wire logic [sadm_pkg::PulseW-1:0]   min_pulse_us_i,
  input  wire logic [sadm_pkg::PulseW-1:0]   max_pulse_us_i,
  input  wire logic [15:0]                   duty_request_i,
  input  wire logic                          write_chip_i,
  // result words
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic                               write_valid_o,
  output logic [7:0]                         reg_addr_o,
  output logic [sadm_pkg::DutyW-1:0]         duty_out_o,
  output logic [7:0]                         angle_out_o
);

  localparam int unsigned IdxW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int unsigned DW   = sadm_pkg::DutyW;
  localparam int unsigned AW   = sadm_pkg::AngleW;
  localparam int unsigned PW   = sadm_pkg::PulseW;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_CHECK    = 11'b000_0000_0010,
    S_CAL_LO   = 11'b000_0000_0100,
    S_CAL_HI   = 11'b000_0000_1000,
    S_ANG_MUL  = 11'b000_0001_0000,
    S_ANG_GO   = 11'b000_0010_0000,
    S_ANG_WAIT = 11'b000_0100_0000,
    S_RB_MUL   = 11'b000_1000_0000,
    S_RB_CHK   = 11'b001_0000_0000,
    S_RB_WAIT  = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [PW-1:0]                period_q;
  logic [sadm_pkg::LimW-1:0]    limit_q;

  // per-servo state
  logic [DW-1:0]        range_low_q  [SERVO_COUNT];
  logic [DW-1:0]        range_high_q [SERVO_COUNT];
  logic signed [AW-1:0] angle_low_q  [SERVO_COUNT];
  logic signed [AW-1:0] angle_high_q [SERVO_COUNT];
  logic [DW-1:0]        duty_store_q [SERVO_COUNT];

  // latched command word
  sadm_pkg::action_e    action_q;
  logic [sadm_pkg::IdW-1:0] id_q;
  logic [7:0]           ang_q;
  logic signed [AW-1:0] amin_q, amax_q;
  logic [PW-1:0]        pmin_q, pmax_q;
  logic [15:0]          dreq_q;
  logic                 wr_q, known_q, in_use_q;

  // result registers
  sadm_pkg::status_e    status_q, status_d;
  logic                 wvalid_q, wvalid_d;
  logic [7:0]           angle_q, angle_d;

  // arithmetic registers
  logic signed [21:0]   prod_q;
  logic signed [29:0]   num_q;

  // divider link
  sadm_pkg::div_req_t   div_req;
  sadm_pkg::div_rsp_t   div_rsp;

  // store write strobes
  logic          we_ang, we_lo, we_hi, we_duty;
  logic [DW-1:0] duty_val;

  logic [IdxW-1:0]           idx;
  logic [sadm_pkg::LimW-1:0] limit_eff;
  logic                      id_known, id_in_use, accept;

  // addressed servo read
  logic [DW-1:0]    lo_rd, hi_rd, duty_rd;
  logic [AW-1:0]    span;
  logic [DW:0]      dr;        // high - low, signed
  logic [DW-1:0]    dr_abs;
  logic [DW:0]      dd;        // duty - low, signed
  logic [PW-1:0]    p_eff;
  logic [21:0]      prod_abs;
  logic [21:0]      q_sgn, duty_sum;
  logic [DW-1:0]    duty_sat;
  logic [29:0]      num_abs;
  logic             res_neg;

  assign accept    = in_valid_i & in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // servo limit in use is the smaller of the register and the store depth
  assign limit_eff = (limit_q < sadm_pkg::LimW'(SERVO_COUNT)) ? limit_q
                                                              : sadm_pkg::LimW'(SERVO_COUNT);
  assign id_known  = servo_id_i < sadm_pkg::IdW'(SERVO_COUNT);
  assign id_in_use = servo_id_i < {3'b000, limit_eff};

  assign idx     = id_q[IdxW-1:0];
  assign lo_rd   = range_low_q[idx];
  assign hi_rd   = range_high_q[idx];
  assign duty_rd = duty_store_q[idx];
  // stored limits always keep low < high, so the span is 1..65535
  assign span    = AW'(angle_high_q[idx] - angle_low_q[idx]);
  assign dr      = {1'b0, hi_rd} - {1'b0, lo_rd};
  assign dr_abs  = dr[DW] ? DW'(-dr) : dr[DW-1:0];
  assign dd      = {1'b0, duty_rd} - {1'b0, lo_rd};

  // zero period counts as one
  assign p_eff = (period_q == '0) ? PW'(1) : period_q;

  assign prod_abs = prod_q[21] ? 22'(-prod_q) : prod_q;

  // floor of a negative quotient rounds away from zero when a remainder is left
  assign q_sgn    = prod_q[21] ? (22'd0 - {2'b00, div_rsp.quot} - 22'(div_rsp.rem != '0))
                               : {2'b00, div_rsp.quot};
  assign duty_sum = q_sgn + {10'd0, lo_rd};
  assign duty_sat = duty_sum[21]          ? '0 :
                    (duty_sum[20:12] != '0) ? sadm_pkg::DutyMax : duty_sum[DW-1:0];

  assign num_abs = num_q[29] ? 30'(-num_q) : num_q;
  // read-back below zero saturates to zero
  assign res_neg = (num_q[29] != dr[DW]) && (num_q != '0);

  // sequencer
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    wvalid_d = wvalid_q;
    angle_d  = angle_q;
    div_req  = '0;
    we_ang   = 1'b0;
    we_lo    = 1'b0;
    we_hi    = 1'b0;
    we_duty  = 1'b0;
    duty_val = duty_sat;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d  = S_CHECK;
          status_d = sadm_pkg::STAT_OK;
          wvalid_d = 1'b0;
          angle_d  = '0;
        end
      end
      S_CHECK: begin
        state_d = S_RB_MUL;
        unique case (action_q)
          sadm_pkg::ACT_CAL: begin
            if (!known_q || pmin_q >= pmax_q || amin_q >= amax_q) begin
              status_d = sadm_pkg::STAT_INVALID;
            end else begin
              we_ang = 1'b1;
              // 4096*pulse/period reaches 4096 exactly when pulse >= period
              if (pmin_q >= p_eff) begin
                status_d = sadm_pkg::STAT_RANGE;
              end else begin
                div_req.start    = 1'b1;
                div_req.rem0     = pmin_q;
                div_req.dividend = '0;
                div_req.divisor  = p_eff;
                div_req.steps    = sadm_pkg::StepsCal;
                state_d          = S_CAL_LO;
              end
            end
          end
          sadm_pkg::ACT_ANGLE: begin
            if (!in_use_q || ang_q > sadm_pkg::AngleMax) begin
              status_d = sadm_pkg::STAT_INVALID;
            end else begin
              state_d = S_ANG_MUL;
            end
          end
          sadm_pkg::ACT_DUTY: begin
            if (!in_use_q || dreq_q[15:DW] != '0) begin
              status_d = sadm_pkg::STAT_INVALID;
            end else begin
              we_duty  = 1'b1;
              duty_val = dreq_q[DW-1:0];
              wvalid_d = wr_q;
            end
          end
          sadm_pkg::ACT_READ: begin
            if (!known_q) begin
              status_d = sadm_pkg::STAT_INVALID;
            end
          end
          default: state_d = S_RB_MUL;
        endcase
      end
      S_CAL_LO: begin
        if (div_rsp.done) begin
          we_lo = 1'b1;
          if (pmax_q >= p_eff) begin
            status_d = sadm_pkg::STAT_RANGE;
            state_d  = S_RB_MUL;
          end else begin
            div_req.start    = 1'b1;
            div_req.rem0     = pmax_q;
            div_req.dividend = '0;
            div_req.divisor  = p_eff;
            div_req.steps    = sadm_pkg::StepsCal;
            state_d          = S_CAL_HI;
          end
        end
      end
      S_CAL_HI: begin
        if (div_rsp.done) begin
          we_hi   = 1'b1;
          state_d = S_RB_MUL;
        end
      end
      S_ANG_MUL: state_d = S_ANG_GO;
      S_ANG_GO: begin
        div_req.start    = 1'b1;
        div_req.rem0     = '0;
        div_req.dividend = prod_abs[sadm_pkg::DivW-1:0];
        div_req.divisor  = {4'd0, span};
        div_req.steps    = sadm_pkg::StepsAng;
        state_d          = S_ANG_WAIT;
      end
      S_ANG_WAIT: begin
        if (div_rsp.done) begin
          we_duty  = 1'b1;
          duty_val = duty_sat;
          wvalid_d = wr_q;
          state_d  = S_RB_MUL;
        end
      end
      S_RB_MUL: begin
        if (!known_q || dr == '0) begin
          angle_d = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_RB_CHK;
        end
      end
      S_RB_CHK: begin
        if (res_neg) begin
          angle_d = '0;
          state_d = S_OUT;
        end else if (num_abs >= {10'd0, dr_abs, 8'd0}) begin
          angle_d = 8'hff;
          state_d = S_OUT;
        end else begin
          // quotient below 256: the top bits seed the remainder, 8 steps remain
          div_req.start    = 1'b1;
          div_req.rem0     = num_abs[27:8];
          div_req.dividend = {num_abs[7:0], 12'd0};
          div_req.divisor  = {8'd0, dr_abs};
          div_req.steps    = sadm_pkg::StepsRead;
          state_d          = S_RB_WAIT;
        end
      end
      S_RB_WAIT: begin
        if (div_rsp.done) begin
          angle_d = div_rsp.quot[7:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= sadm_pkg::STAT_OK;
      wvalid_q <= 1'b0;
      angle_q  <= '0;
      period_q <= sadm_pkg::PeriodReset;
      limit_q  <= sadm_pkg::LimitReset;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      wvalid_q <= wvalid_d;
      angle_q  <= angle_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          sadm_pkg::RegPeriod: period_q <= cfg_wdata_i;
          sadm_pkg::RegLimit:  limit_q  <= cfg_wdata_i[sadm_pkg::LimW-1:0];
          default: ;
        endcase
      end
    end
  end

  // per-servo calibration and duty store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        range_low_q[i]  <= '0;
        range_high_q[i] <= sadm_pkg::DutyMax;
        angle_low_q[i]  <= '0;
        angle_high_q[i] <= sadm_pkg::AngleHighReset;
        duty_store_q[i] <= '0;
      end
    end else begin
      if (we_ang) begin
        angle_low_q[idx]  <= amin_q;
        angle_high_q[idx] <= amax_q;
      end
      if (we_lo) begin
        range_low_q[idx] <= div_rsp.quot[DW-1:0];
      end
      if (we_hi) begin
        range_high_q[idx] <= div_rsp.quot[DW-1:0];
      end
      if (we_duty) begin
        duty_store_q[idx] <= duty_val;
      end
    end
  end

  // command latch and multiply stages
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= sadm_pkg::action_e'(action_i);
      id_q     <= servo_id_i;
      ang_q    <= angle_i;
      amin_q   <= cal_lo_angle_i;
      amax_q   <= cal_hi_angle_i;
      pmin_q   <= min_pulse_us_i;
      pmax_q   <= max_pulse_us_i;
      dreq_q   <= duty_request_i;
      wr_q     <= write_chip_i;
      known_q  <= id_known;
      in_use_q <= id_in_use;
    end
    // (high - low) * angle for the set-angle slope
    if (state_q == S_ANG_MUL) begin
      prod_q <= 22'($signed(dr) * $signed({1'b0, ang_q}));
    end
    // (duty - low) * angle span for the read-back
    if (state_q == S_RB_MUL) begin
      num_q <= 30'($signed(dd) * $signed({1'b0, span}));
    end
  end

  sadm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // result word
  assign status_o      = status_q;
  assign write_valid_o = wvalid_q;
  assign reg_addr_o    = wvalid_q ? (sadm_pkg::RegBase + {id_q[5:0], 2'b00}) : 8'd0;
  assign duty_out_o    = known_q ? duty_rd : '0;
  assign angle_out_o   = angle_q;

endmodule

`default_nettype wire

// ===== rtl/core/sadm_checker.sv =====
// port-level checks of the servo angle to duty mapper, bound to the top level
`default_nettype none

module sadm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] status_o,
  input wire logic       write_valid_o,
  input wire logic [7:0] reg_addr_o
);

  // one word in flight: never ready while a result is shown
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // an accepted word shows no result in the cycle after it is taken
  a_no_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result shown right after accept");

  // chip writes come only with success
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_valid_o) |-> (status_o == 2'd0))
    else $error("chip write on a failed command");

  // no address without a write
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_valid_o) |-> (reg_addr_o == 8'd0))
    else $error("register address without a write");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

bind servo_angle_duty_mapper sadm_checker u_sadm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .write_valid_o (write_valid_o),
  .reg_addr_o    (reg_addr_o)
);

`default_nettype wire

// ===== tb/sv/servo_angle_duty_mapper_tb.sv =====
// self-checking testbench for servo_angle_duty_mapper: directed corners, then random words
`timescale 1ns / 1ps

module servo_angle_duty_mapper_tb;

  localparam int unsigned SERVO_N = sadm_pkg::ServoCountDef;

  // one command word as the sender sees it
  typedef struct {
    sadm_pkg::action_e                  action;
    logic [sadm_pkg::IdW-1:0]           servo_id;
    logic [7:0]                         angle;
    logic signed [sadm_pkg::AngleW-1:0] cal_lo_angle;
    logic signed [sadm_pkg::AngleW-1:0] cal_hi_angle;
    logic [sadm_pkg::PulseW-1:0]        min_pulse;
    logic [sadm_pkg::PulseW-1:0]        max_pulse;
    logic [15:0]                        duty_request;
    logic                               write_chip;
  } servo_cmd_t;

  // one result word
  typedef struct {
    sadm_pkg::status_e          status;
    logic                       write_valid;
    logic [7:0]                 reg_addr;
    logic [sadm_pkg::DutyW-1:0] duty;
    logic [7:0]                 angle;
  } servo_word_t;

  // clock, reset and every block input start at known values
  logic                               clk_i          = 1'b0;
  logic                               rst_ni         = 1'b0;
  logic                               cfg_we_i       = 1'b0;
  logic                               cfg_addr_i     = sadm_pkg::RegPeriod;
  logic [sadm_pkg::PulseW-1:0]        cfg_wdata_i    = '0;
  logic                               in_valid_i     = 1'b0;
  logic [1:0]                         action_i       = sadm_pkg::ACT_READ;
  logic [sadm_pkg::IdW-1:0]           servo_id_i     = '0;
  logic [7:0]                         angle_i        = '0;
  logic signed [sadm_pkg::AngleW-1:0] cal_lo_angle_i = '0;
  logic signed [sadm_pkg::AngleW-1:0] cal_hi_angle_i = '0;
  logic [sadm_pkg::PulseW-1:0]        min_pulse_us_i = '0;
  logic [sadm_pkg::PulseW-1:0]        max_pulse_us_i = '0;
  logic [15:0]                        duty_request_i = '0;
  logic                               write_chip_i   = 1'b0;
  logic                               out_ready_i    = 1'b0;

  logic                       in_ready_o;
  logic                       out_valid_o;
  logic [1:0]                 status_o;
  logic                       write_valid_o;
  logic [7:0]                 reg_addr_o;
  logic [sadm_pkg::DutyW-1:0] duty_out_o;
  logic [7:0]                 angle_out_o;

  servo_angle_duty_mapper DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .servo_id_i     (servo_id_i),
    .angle_i        (angle_i),
    .cal_lo_angle_i (cal_lo_angle_i),
    .cal_hi_angle_i (cal_hi_angle_i),
    .min_pulse_us_i (min_pulse_us_i),
    .max_pulse_us_i (max_pulse_us_i),
    .duty_request_i (duty_request_i),
    .write_chip_i   (write_chip_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .write_valid_o  (write_valid_o),
    .reg_addr_o     (reg_addr_o),
    .duty_out_o     (duty_out_o),
    .angle_out_o    (angle_out_o)
  );

  // ---------------------------------------------------------------------------
  // predictor state: shadow copy of the per-servo calibration and duty store
  // ---------------------------------------------------------------------------
  logic [sadm_pkg::PulseW-1:0]        period_reg;
  logic [sadm_pkg::LimW-1:0]          limit_reg;
  logic [sadm_pkg::DutyW-1:0]         duty_lo  [SERVO_N];
  logic [sadm_pkg::DutyW-1:0]         duty_hi  [SERVO_N];
  logic signed [sadm_pkg::AngleW-1:0] ang_lo   [SERVO_N];
  logic signed [sadm_pkg::AngleW-1:0] ang_hi   [SERVO_N];
  logic [sadm_pkg::DutyW-1:0]         duty_now [SERVO_N];

  servo_cmd_t  pending_cmds[$];     // words waiting for the driver
  servo_word_t predicted_words[$];  // results owed by the block, oldest first

  int err_count  = 0;
  int sent_count = 0;
  int recv_count = 0;
  int tx_mode    = 1;  // 0 back to back, 1 random gaps, 2 rare gaps
  int rx_mode    = 1;
  int tx_gap     = 0;
  int rx_stall   = 0;
  servo_cmd_t cur_cmd;

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #1_500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // floor division, rounding toward minus infinity for mixed signs
  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && ((num < 0) != (den < 0))) q = q - 1;
    return q;
  endfunction

  // angle span of a servo; a non-positive span counts as one
  function automatic longint span_of(int s);
    longint sp;
    sp = longint'(ang_hi[s]) - longint'(ang_lo[s]);
    return (sp > 0) ? sp : 1;
  endfunction

  // pulse width to 12-bit duty, a zero period counts as one
  function automatic longint unsigned pulse_duty(logic [sadm_pkg::PulseW-1:0] pulse);
    longint unsigned p;
    p = (period_reg == 0) ? 64'd1 : 64'(period_reg);
    return (64'd4096 * 64'(pulse)) / p;
  endfunction

  // angle read back from the stored duty: subtract, scale, divide, saturate
  function automatic logic [7:0] angle_from_duty(int s);
    longint dr;
    longint a;
    dr = longint'(duty_hi[s]) - longint'(duty_lo[s]);
    if (dr == 0) return 8'd0;  // flat duty range
    a = floor_quot((longint'(duty_now[s]) - longint'(duty_lo[s])) * span_of(s), dr);
    if (a < 0) a = 0;
    if (a > 255) a = 255;
    return a[7:0];
  endfunction

  // expected result of one accepted command; updates the shadow state
  function automatic servo_word_t map_servo_command(servo_cmd_t c);
    servo_word_t r;
    int unsigned lim;
    bit known;
    bit in_use;
    bit bad;
    longint unsigned d;
    longint duty;
    r.status      = sadm_pkg::STAT_OK;
    r.write_valid = 1'b0;
    r.reg_addr    = '0;
    lim    = (limit_reg < SERVO_N) ? 32'(limit_reg) : SERVO_N;
    known  = c.servo_id < SERVO_N;
    in_use = c.servo_id < lim;
    case (c.action)
      sadm_pkg::ACT_CAL: begin
        if (!known || c.min_pulse >= c.max_pulse || c.cal_lo_angle >= c.cal_hi_angle) begin
          r.status = sadm_pkg::STAT_INVALID;
        end else begin
          // angles first, then low duty, then high duty; a failure keeps earlier stores
          ang_lo[c.servo_id] = c.cal_lo_angle;
          ang_hi[c.servo_id] = c.cal_hi_angle;
          d = pulse_duty(c.min_pulse);
          if (d >= 4096) begin
            r.status = sadm_pkg::STAT_RANGE;
          end else begin
            duty_lo[c.servo_id] = d[sadm_pkg::DutyW-1:0];
            d = pulse_duty(c.max_pulse);
            if (d >= 4096) r.status = sadm_pkg::STAT_RANGE;
            else duty_hi[c.servo_id] = d[sadm_pkg::DutyW-1:0];
          end
        end
      end
      sadm_pkg::ACT_ANGLE, sadm_pkg::ACT_DUTY: begin
        if (c.action == sadm_pkg::ACT_ANGLE) bad = c.angle > sadm_pkg::AngleMax;
        else bad = c.duty_request >= 16'd4096;
        if (!in_use || bad) begin
          r.status = sadm_pkg::STAT_INVALID;
        end else begin
          if (c.action == sadm_pkg::ACT_ANGLE) begin
            // the low angle only sets the slope, the offset is always the low duty
            duty = longint'(duty_lo[c.servo_id]) +
                   floor_quot((longint'(duty_hi[c.servo_id]) -
                               longint'(duty_lo[c.servo_id])) * longint'(c.angle),
                              span_of(c.servo_id));
            if (duty < 0) duty = 0;
            if (duty > longint'(sadm_pkg::DutyMax)) duty = longint'(sadm_pkg::DutyMax);
          end else begin
            duty = longint'(c.duty_request);
          end
          duty_now[c.servo_id] = duty[sadm_pkg::DutyW-1:0];
          if (c.write_chip) begin
            r.write_valid = 1'b1;
            r.reg_addr    = sadm_pkg::RegBase + (c.servo_id << 2);
          end
        end
      end
      default: begin
        if (!known) r.status = sadm_pkg::STAT_INVALID;
      end
    endcase
    r.duty  = known ? duty_now[c.servo_id] : '0;
    r.angle = known ? angle_from_duty(c.servo_id) : '0;
    return r;
  endfunction

  // idle cycles before the next word, by the current gap mode
  function automatic int idle_draw(int mode);
    case (mode)
      0:       return 0;
      1:       return int'($urandom_range(0, 19));
      default: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 19)) : 0;
    endcase
  endfunction

  // random command, mostly well-formed for the current register values
  function automatic servo_cmd_t random_command();
    servo_cmd_t c;
    int unsigned lim;
    int unsigned pe;
    int amin;
    c.action       = sadm_pkg::action_e'($urandom_range(0, 3));
    c.servo_id     = 8'($urandom);
    c.angle        = 8'($urandom);
    c.cal_lo_angle = 16'($urandom);
    c.cal_hi_angle = 16'($urandom);
    c.min_pulse    = 20'($urandom);
    c.max_pulse    = 20'($urandom);
    c.duty_request = 16'($urandom);
    c.write_chip   = 1'($urandom);
    // one word in ten stays raw noise
    if ($urandom_range(0, 9) == 0) return c;

    lim = (limit_reg < SERVO_N) ? 32'(limit_reg) : SERVO_N;
    if (lim > 0 && $urandom_range(0, 5) != 0) c.servo_id = 8'($urandom_range(0, lim - 1));
    else c.servo_id = 8'($urandom_range(0, SERVO_N + 1));
    c.angle = 8'(($urandom_range(0, 19) != 0) ? $urandom_range(0, 180)
                                              : $urandom_range(181, 255));
    c.duty_request = 16'(($urandom_range(0, 19) != 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(4096, 65535));
    if (c.action == sadm_pkg::ACT_CAL) begin
      case ($urandom_range(0, 2))
        0: begin
          c.cal_lo_angle = 16'd0;
          c.cal_hi_angle = 16'd180;
        end
        1: begin
          // narrow span: steep slope, duty saturates
          amin = int'($urandom_range(0, 400)) - 200;
          c.cal_lo_angle = 16'(amin);
          c.cal_hi_angle = 16'(amin + int'($urandom_range(1, 10)));
        end
        default: begin
          amin = int'($urandom_range(0, 65534)) - 32768;
          c.cal_lo_angle = 16'(amin);
          c.cal_hi_angle = 16'(amin + 1 + int'($urandom_range(0, 32766 - amin)));
        end
      endcase
      // a pulse below the period gives a duty below 4096
      pe = (period_reg == 0) ? 1 : 32'(period_reg);
      if (pe >= 2 && $urandom_range(0, 6) != 0) begin
        c.min_pulse = 20'($urandom_range(0, pe - 2));
        if ($urandom_range(0, 6) == 0)
          c.max_pulse = 20'($urandom_range(32'(c.min_pulse) + 1, 20'hFFFFF));
        else
          c.max_pulse = 20'($urandom_range(32'(c.min_pulse) + 1, pe - 1));
      end
    end
    return c;
  endfunction

  task automatic push_cmd(sadm_pkg::action_e a, int id, int ang, int amin, int amax,
                          int pmin, int pmax, int dreq, bit wr);
    servo_cmd_t c;
    c.action       = a;
    c.servo_id     = 8'(id);
    c.angle        = 8'(ang);
    c.cal_lo_angle = 16'(amin);
    c.cal_hi_angle = 16'(amax);
    c.min_pulse    = 20'(pmin);
    c.max_pulse    = 20'(pmax);
    c.duty_request = 16'(dreq);
    c.write_chip   = wr;
    pending_cmds.push_back(c);
  endtask

  task automatic push_random(int n);
    repeat (n) pending_cmds.push_back(random_command());
  endtask

  // sender holds off until every word is sent and every result is back
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid_i || predicted_words.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [sadm_pkg::PulseW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    if (idx == sadm_pkg::RegPeriod) period_reg = val;
    else limit_reg = val[sadm_pkg::LimW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic set_regs(logic [sadm_pkg::PulseW-1:0] per, logic [sadm_pkg::LimW-1:0] lim);
    wait_drained();
    write_reg(sadm_pkg::RegPeriod, per);
    write_reg(sadm_pkg::RegLimit, {{(sadm_pkg::PulseW-sadm_pkg::LimW){1'b0}}, lim});
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the next pending word after a drawn gap
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : cmd_drive
    bit offer;
    if (rst_ni) begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predicted_words.push_back(map_servo_command(cur_cmd));
        sent_count++;
        if (sent_count % 64 == 0) tx_mode = int'($urandom_range(0, 2));
        tx_gap = idle_draw(tx_mode);
        offer  = 1'b0;
      end
      if (!offer) begin
        if (tx_gap == 0 && pending_cmds.size() > 0) begin
          cur_cmd         = pending_cmds.pop_front();
          action_i       <= cur_cmd.action;
          servo_id_i     <= cur_cmd.servo_id;
          angle_i        <= cur_cmd.angle;
          cal_lo_angle_i <= cur_cmd.cal_lo_angle;
          cal_hi_angle_i <= cur_cmd.cal_hi_angle;
          min_pulse_us_i <= cur_cmd.min_pulse;
          max_pulse_us_i <= cur_cmd.max_pulse;
          duty_request_i <= cur_cmd.duty_request;
          write_chip_i   <= cur_cmd.write_chip;
          offer = 1'b1;
        end else if (tx_gap > 0) begin
          tx_gap--;
        end
      end
      // valid stays up with the payload frozen until the word is taken
      in_valid_i <= offer;
    end
  end

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: takes results with random stalls, checks against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    servo_word_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_words.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d duty %0d",
                   $time, status_o, duty_out_o);
          err_count++;
        end else begin
          w = predicted_words.pop_front();
          check_field("status", 32'(w.status), 32'(status_o));
          check_field("write_valid", 32'(w.write_valid), 32'(write_valid_o));
          check_field("reg_addr", 32'(w.reg_addr), 32'(reg_addr_o));
          check_field("duty_out", 32'(w.duty), 32'(duty_out_o));
          check_field("angle_out", 32'(w.angle), 32'(angle_out_o));
        end
        recv_count++;
        if (recv_count % 64 == 0) rx_mode = int'($urandom_range(0, 2));
        rx_stall = idle_draw(rx_mode);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      out_ready_i <= (rx_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: phases separated by register writes with the block drained
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    period_reg = sadm_pkg::PeriodReset;
    limit_reg  = sadm_pkg::LimitReset;
    for (int i = 0; i < SERVO_N; i++) begin
      duty_lo[i]  = '0;
      duty_hi[i]  = sadm_pkg::DutyMax;
      ang_lo[i]   = '0;
      ang_hi[i]   = sadm_pkg::AngleHighReset;
      duty_now[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default registers, directed corners
    set_regs(20'd20000, 5'd16);
    push_cmd(sadm_pkg::ACT_READ,  0,   0, 0, 0, 0, 0, 0, 0);      // reset state read back
    push_cmd(sadm_pkg::ACT_READ,  255, 0, 0, 0, 0, 0, 0, 0);      // unknown servo
    push_cmd(sadm_pkg::ACT_ANGLE, 0,   180, 0, 0, 0, 0, 0, 1);    // full scale with chip write
    push_cmd(sadm_pkg::ACT_ANGLE, 15,  0, 0, 0, 0, 0, 0, 1);      // last servo, zero angle
    push_cmd(sadm_pkg::ACT_ANGLE, 0,   181, 0, 0, 0, 0, 0, 1);    // angle past 180
    push_cmd(sadm_pkg::ACT_ANGLE, 16,  90, 0, 0, 0, 0, 0, 1);     // servo past the count
    push_cmd(sadm_pkg::ACT_DUTY,  3,   0, 0, 0, 0, 0, 4095, 1);   // top duty
    push_cmd(sadm_pkg::ACT_DUTY,  3,   0, 0, 0, 0, 0, 4096, 1);   // duty out of range
    push_cmd(sadm_pkg::ACT_DUTY,  5,   255, 0, 0, 0, 0, 0, 0);    // zero duty, no chip write
    push_cmd(sadm_pkg::ACT_CAL,   2,   0, -32768, 32767, 0, 19999, 0, 0); // widest span
    push_cmd(sadm_pkg::ACT_ANGLE, 2,   180, 0, 0, 0, 0, 0, 1);
    push_cmd(sadm_pkg::ACT_CAL,   2,   0, 0, 180, 500, 500, 0, 0);   // equal pulses
    push_cmd(sadm_pkg::ACT_CAL,   2,   0, 90, 90, 500, 900, 0, 0);   // equal angles
    push_cmd(sadm_pkg::ACT_CAL,   16,  0, 0, 180, 500, 900, 0, 0);   // unknown servo
    push_cmd(sadm_pkg::ACT_CAL,   9,   0, 0, 180, 1000, 20000, 0, 0); // high duty overflows
    push_cmd(sadm_pkg::ACT_CAL,   10,  0, 0, 180, 1048574, 1048575, 65535, 1); // low overflows
    push_cmd(sadm_pkg::ACT_CAL,   4,   0, 0, 1, 1000, 2000, 0, 0);   // span of one
    push_cmd(sadm_pkg::ACT_ANGLE, 4,   180, 0, 0, 0, 0, 0, 0);       // saturates high
    push_cmd(sadm_pkg::ACT_CAL,   6,   0, 0, 180, 0, 1000, 0, 0);
    push_cmd(sadm_pkg::ACT_CAL,   6,   0, -90, -88, 15000, 25000, 0, 0); // low above high
    push_cmd(sadm_pkg::ACT_ANGLE, 6,   180, 0, 0, 0, 0, 0, 1);       // saturates low
    push_cmd(sadm_pkg::ACT_READ,  6,   0, 0, 0, 0, 0, 0, 0);         // falling range read-back
    push_random(300);

    // long period: tiny duties, flat ranges; one servo in use
    set_regs(20'd1000000, 5'd1);
    push_cmd(sadm_pkg::ACT_CAL,   0, 0, 0, 180, 1, 2, 0, 0);
    push_cmd(sadm_pkg::ACT_ANGLE, 0, 90, 0, 0, 0, 0, 0, 1);
    push_cmd(sadm_pkg::ACT_READ,  0, 0, 0, 0, 0, 0, 0, 0);
    push_random(60);

    // zero period counts as one; no servo in use
    set_regs(20'd0, 5'd0);
    push_cmd(sadm_pkg::ACT_CAL,  8, 0, 0, 180, 1, 2, 0, 0);
    push_cmd(sadm_pkg::ACT_DUTY, 0, 0, 0, 0, 0, 0, 100, 1);
    push_cmd(sadm_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    push_random(40);

    set_regs(20'd1, 5'd31);
    push_random(40);
    set_regs(20'hFFFFF, 5'd16);
    push_random(150);
    set_regs(20'd20000, 5'd8);
    push_random(200);
    repeat (3) begin
      set_regs(20'($urandom_range(2000, 60000)), 5'($urandom_range(1, 16)));
      push_random(100);
    end

    // everything back, then a quiet stretch for stray results
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (err_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
